/* rtl/plu_pkg.sv */
//------------------------------------------------------------------------------
// plu_pkg
// Shared widths, register indexes and fixed-point helpers for the pixel lift.
//------------------------------------------------------------------------------
package plu_pkg;

   localparam int CoordW = 24;
   localparam int PixW   = 16;
   // wide enough for every intermediate of one distortion evaluation
   localparam int WideW  = 52;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [WideW-1:0]  wide_type;

   typedef enum logic [2:0] {
      REG_INV_FX = 3'd0,
      REG_INV_FY = 3'd1,
      REG_OFF_X  = 3'd2,
      REG_OFF_Y  = 3'd3,
      REG_K1     = 3'd4,
      REG_K2     = 3'd5,
      REG_P1     = 3'd6,
      REG_P2     = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [23:0] inv_fx;
      logic [23:0] inv_fy;
      coord_type   off_x;
      coord_type   off_y;
      coord_type   k1;
      coord_type   k2;
      coord_type   p1;
      coord_type   p2;
   } cfg_type;

   // item travelling down the pipe
   typedef struct packed {
      logic      vld;
      logic      mode;
      coord_type dx;
      coord_type dy;
      coord_type ux;
      coord_type uy;
   } item_type;

   // round half up from Q.40 product to Q.20 (arithmetic shift is floor)
   function automatic wide_type rnd20(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = (v + 64'sd524288) >>> 20;
      return t[WideW-1:0];
   endfunction

   function automatic coord_type sat24(input wide_type v);
      if (v > wide_type'(8388607))
         return coord_type'(24'sh7fffff);
      else if (v < -wide_type'(8388608))
         return coord_type'(24'sh800000);
      else
         return v[CoordW-1:0];
   endfunction

endpackage

/* rtl/plu_norm.sv */
//------------------------------------------------------------------------------
// plu_norm
// Pixel to normalized coordinates: multiply by inverse focal, round, offset.
// Two register stages.
//------------------------------------------------------------------------------
module plu_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic [15:0]         pixel_x,
   input  logic [15:0]         pixel_y,
   input  logic                mode,
   input  plu_pkg::cfg_type    cfg,
   output plu_pkg::item_type   item_out
);
   import plu_pkg::*;

   logic        vld1_ff, mode1_ff;
   logic [39:0] px_ff, py_ff;
   logic [39:0] px_in, py_in;
   item_type    out_ff, out_in;
   wide_type    sx, sy;

   assign px_in = 40'(pixel_x) * 40'(cfg.inv_fx);
   assign py_in = 40'(pixel_y) * 40'(cfg.inv_fy);

   always_comb begin
      sx = wide_type'((px_ff + 40'd128) >> 8) + wide_type'(cfg.off_x);
      sy = wide_type'((py_ff + 40'd128) >> 8) + wide_type'(cfg.off_y);
      out_in.vld  = vld1_ff;
      out_in.mode = mode1_ff;
      out_in.dx   = sat24(sx);
      out_in.dy   = sat24(sy);
      out_in.ux   = sat24(sx);
      out_in.uy   = sat24(sy);
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      mode1_ff <= mode;
      if (reset) begin
         vld1_ff <= 1'b0;
         out_ff  <= '0;
      end else begin
         vld1_ff <= in_vld;
         out_ff  <= out_in;
      end
   end

   assign item_out = out_ff;
endmodule

/* rtl/plu_iter.sv */
//------------------------------------------------------------------------------
// plu_iter
// One undistortion iterate u = d - D(u), pipelined over five stages.
// Items in mode 0 pass with u unchanged.
//------------------------------------------------------------------------------
module plu_iter (
   input  logic                clock,
   input  logic                reset,
   input  plu_pkg::cfg_type    cfg,
   input  plu_pkg::item_type   item_in,
   output plu_pkg::item_type   item_out
);
   import plu_pkg::*;

   // stage a: squares and cross term
   item_type a_ff;
   wide_type x2_ff, y2_ff, xy_ff;
   // stage b: r, r2
   item_type b_ff;
   wide_type bx2_ff, by2_ff, bxy_ff, r_ff, r2_ff;
   // stage c: radial and tangential products
   item_type c_ff;
   wide_type rad_ff, t1x_ff, t1y_ff, t2x_ff, t2y_ff;
   // stage d: u times rad, tangential sums
   item_type d_ff;
   wide_type mx_ff, my_ff, tx_ff, ty_ff;
   // stage e: subtract from d and saturate
   item_type e_ff, e_in;

   wide_type r_in;
   wide_type dxw, dyw;

   assign r_in = x2_ff + y2_ff;

   // every second factor fits 40 signed bits (rad stays below 2^38)
   function automatic wide_type mulr(input coord_type a, input logic signed [39:0] b);
      return rnd20(64'(a) * 64'(b));
   endfunction

   // r is at most 2^27
   function automatic wide_type sqr(input logic signed [28:0] a);
      return rnd20(64'(a) * 64'(a));
   endfunction

   always_comb begin
      e_in = d_ff;
      dxw  = mx_ff + tx_ff;
      dyw  = my_ff + ty_ff;
      if (d_ff.mode) begin
         e_in.ux = sat24(wide_type'(d_ff.dx) - dxw);
         e_in.uy = sat24(wide_type'(d_ff.dy) - dyw);
      end
   end

   always_ff @(posedge clock) begin
      x2_ff  <= mulr(item_in.ux, 40'(item_in.ux));
      y2_ff  <= mulr(item_in.uy, 40'(item_in.uy));
      xy_ff  <= mulr(item_in.ux, 40'(item_in.uy));

      bx2_ff <= x2_ff;
      by2_ff <= y2_ff;
      bxy_ff <= xy_ff;
      r_ff   <= r_in;
      r2_ff  <= sqr(r_in[28:0]);

      rad_ff <= mulr(cfg.k1, r_ff[39:0]) + mulr(cfg.k2, r2_ff[39:0]);
      t1x_ff <= mulr(cfg.p1, bxy_ff[39:0]);
      t1y_ff <= mulr(cfg.p2, bxy_ff[39:0]);
      t2x_ff <= mulr(cfg.p2, 40'(r_ff + (bx2_ff <<< 1)));
      t2y_ff <= mulr(cfg.p1, 40'(r_ff + (by2_ff <<< 1)));

      mx_ff  <= mulr(c_ff.ux, rad_ff[39:0]);
      my_ff  <= mulr(c_ff.uy, rad_ff[39:0]);
      tx_ff  <= (t1x_ff <<< 1) + t2x_ff;
      ty_ff  <= (t1y_ff <<< 1) + t2y_ff;

      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
         d_ff <= '0;
         e_ff <= '0;
      end else begin
         a_ff <= item_in;
         b_ff <= a_ff;
         c_ff <= b_ff;
         d_ff <= c_ff;
         e_ff <= e_in;
      end
   end

   assign item_out = e_ff;
endmodule

/* rtl/plu_csr.sv */
//------------------------------------------------------------------------------
// plu_csr
// APB-style register file for focal, offset and distortion coefficients.
//------------------------------------------------------------------------------
module plu_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output plu_pkg::cfg_type   cfg
);
   import plu_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr;

   assign idx    = reg_idx_type'(paddr[4:2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_INV_FX: cfg_in.inv_fx = pwdata[23:0];
            REG_INV_FY: cfg_in.inv_fy = pwdata[23:0];
            REG_OFF_X:  cfg_in.off_x  = pwdata[23:0];
            REG_OFF_Y:  cfg_in.off_y  = pwdata[23:0];
            REG_K1:     cfg_in.k1     = pwdata[23:0];
            REG_K2:     cfg_in.k2     = pwdata[23:0];
            REG_P1:     cfg_in.p1     = pwdata[23:0];
            REG_P2:     cfg_in.p2     = pwdata[23:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_INV_FX: prdata = {8'd0, cfg_ff.inv_fx};
         REG_INV_FY: prdata = {8'd0, cfg_ff.inv_fy};
         REG_OFF_X:  prdata = {8'd0, cfg_ff.off_x};
         REG_OFF_Y:  prdata = {8'd0, cfg_ff.off_y};
         REG_K1:     prdata = {8'd0, cfg_ff.k1};
         REG_K2:     prdata = {8'd0, cfg_ff.k2};
         REG_P1:     prdata = {8'd0, cfg_ff.p1};
         REG_P2:     prdata = {8'd0, cfg_ff.p2};
         default:    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{inv_fx: 24'd32768, inv_fy: 24'd32768, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

/* rtl/pixel_lift_iterative_undistort.sv */
// Throughput: one word per cycle; busy is always low, set by the unrolled chain
// of ITERATIONS+1 five-stage iterate units after a two-stage normalizer.
// Reset: synchronous, clears the valid bits and sets the configuration registers to reset values.
// The receiver cannot stall; each result shows for one cycle under rsp_valid.
//------------------------------------------------------------------------------
// pixel_lift_iterative_undistort
// Pixel lift to normalized coordinates with iterative lens undistortion.
//------------------------------------------------------------------------------
module pixel_lift_iterative_undistort #(
   parameter int ITERATIONS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [15:0]  req_pixel_x,
   input  logic [15:0]  req_pixel_y,
   input  logic         req_mode,
   output logic         rsp_valid,
   output logic [23:0]  rsp_norm_x,
   output logic [23:0]  rsp_norm_y,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import plu_pkg::*;

   cfg_type  cfg;
   item_type chain [ITERATIONS+2];

   assign busy = 1'b0;

   plu_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg
   );

   plu_norm u_norm (
      .clock, .reset, .in_vld(start), .pixel_x(req_pixel_x),
      .pixel_y(req_pixel_y), .mode(req_mode), .cfg, .item_out(chain[0])
   );

   for (genvar g = 0; g <= ITERATIONS; g++) begin : g_iter
      plu_iter u_iter (
         .clock, .reset, .cfg, .item_in(chain[g]), .item_out(chain[g+1])
      );
   end

   assign rsp_valid  = chain[ITERATIONS+1].vld;
   assign rsp_norm_x = chain[ITERATIONS+1].ux;
   assign rsp_norm_y = chain[ITERATIONS+1].uy;

`ifndef SYNTH
   a_valid_latency: assert property (@(posedge clock) disable iff (reset)
      $past(start, 2) && !$past(reset, 1) && !$past(reset, 2) |-> chain[0].vld)
      else $error("normalizer lost a word");
   a_mode0_pass: assert property (@(posedge clock) disable iff (reset)
      chain[ITERATIONS+1].vld && !chain[ITERATIONS+1].mode |->
      chain[ITERATIONS+1].ux == chain[ITERATIONS+1].dx)
      else $error("mode 0 word altered");
   a_not_busy: assert property (@(posedge clock) !busy)
      else $error("busy asserted");
`endif
endmodule

/* tb/pixel_lift_iterative_undistort_test.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// pixel_lift_iterative_undistort_test
// Drives pixel coordinates through the lift, predicts the normalized and
// undistorted point in fixed point, and compares every result word in order.
// Register settings change between phases while the pipe is drained.
//------------------------------------------------------------------------------
module pixel_lift_iterative_undistort_test;
   import plu_pkg::*;

   localparam int NumIter    = 8;
   localparam int Latency    = 2 + 5*(NumIter+1);
   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic [15:0] px;
      logic [15:0] py;
      logic        mode;
   } pixel_word_type;

   typedef struct packed {
      logic [23:0] nx;
      logic [23:0] ny;
   } norm_word_type;

   logic        clock, reset, start, busy;
   logic [15:0] req_pixel_x, req_pixel_y;
   logic        req_mode;
   logic        rsp_valid;
   logic [23:0] rsp_norm_x, rsp_norm_y;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   pixel_lift_iterative_undistort #(.ITERATIONS(NumIter)) uut (.*);

   pixel_word_type pending_words[$];
   norm_word_type  expected_norms[$];
   logic [23:0]    lens_regs[8];
   int  mismatches = 0;
   int  cycles = 0;
   int  gap_left = 0;
   bit  allow_gaps = 1;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint sx24(logic [23:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // floor((v + 2^19) / 2^20)
   function automatic longint round_q20(longint v);
      return (v + 64'sd524288) >>> 20;
   endfunction

   function automatic longint lift_axis(logic [15:0] p, logic [23:0] inv, logic [23:0] off);
      longint prod;
      prod = longint'(p) * longint'(inv);
      return clamp24(((prod + 128) >>> 8) + sx24(off));
   endfunction

   function automatic void lens_shift(longint x, longint y, output longint ex,
                                      output longint ey);
      longint k1, k2, p1, p2, x2, y2, xy, r, r2, rad;
      k1 = sx24(lens_regs[REG_K1]);
      k2 = sx24(lens_regs[REG_K2]);
      p1 = sx24(lens_regs[REG_P1]);
      p2 = sx24(lens_regs[REG_P2]);
      x2 = round_q20(x*x);
      y2 = round_q20(y*y);
      xy = round_q20(x*y);
      r = x2 + y2;
      r2 = round_q20(r*r);
      rad = round_q20(k1*r) + round_q20(k2*r2);
      ex = round_q20(x*rad) + 2*round_q20(p1*xy) + round_q20(p2*(r + 2*x2));
      ey = round_q20(y*rad) + 2*round_q20(p2*xy) + round_q20(p1*(r + 2*y2));
   endfunction

   function automatic norm_word_type undistort_point(pixel_word_type w);
      longint dx, dy, ux, uy, ex, ey;
      norm_word_type n;
      dx = lift_axis(w.px, lens_regs[REG_INV_FX], lens_regs[REG_OFF_X]);
      dy = lift_axis(w.py, lens_regs[REG_INV_FY], lens_regs[REG_OFF_Y]);
      ux = dx;
      uy = dy;
      if (w.mode) begin
         for (int i = 0; i <= NumIter; i++) begin
            lens_shift(ux, uy, ex, ey);
            ux = clamp24(dx - ex);
            uy = clamp24(dy - ey);
         end
      end
      n.nx = ux[23:0];
      n.ny = uy[23:0];
      return n;
   endfunction

   // driver: one word per accepted start, random gap bursts
   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (start && !busy) begin
         // word taken at the edge just passed
         expected_norms = {expected_norms, undistort_point(pending_words.pop_front())};
         if (allow_gaps && gap_left == 0 && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 16);
         if (pending_words.size() > 0 && gap_left == 0) begin
            req_pixel_x <= pending_words[0].px;
            req_pixel_y <= pending_words[0].py;
            req_mode <= pending_words[0].mode;
         end else begin
            start <= 0;
         end
      end else if (!start) begin
         if (gap_left > 1) begin
            gap_left = gap_left - 1;
         end else if (pending_words.size() > 0) begin
            gap_left = 0;
            start <= 1;
            req_pixel_x <= pending_words[0].px;
            req_pixel_y <= pending_words[0].py;
            req_mode <= pending_words[0].mode;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      norm_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_norms.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h %h", rsp_norm_x, rsp_norm_y);
         end else begin
            want = expected_norms.pop_front();
            if (want.nx !== rsp_norm_x || want.ny !== rsp_norm_y) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x %h y %h, got x %h y %h",
                           want.nx, want.ny, rsp_norm_x, rsp_norm_y);
            end
         end
      end
   end

   task automatic csr_write(reg_idx_type idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= 5'(idx) << 2; pwdata <= val;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      lens_regs[idx] = val[23:0];
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic queue_word(logic [15:0] px, logic [15:0] py, logic mode);
      pixel_word_type w;
      w.px = px; w.py = py; w.mode = mode;
      pending_words = {pending_words, w};
   endtask

   task automatic drain;
      while (pending_words.size() > 0 || start || expected_norms.size() > 0)
         @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   // small coefficient, mostly well-behaved lens
   function automatic logic [31:0] mild_coeff();
      return 32'($signed($urandom_range(0, 400000)) - 200000);
   endfunction

   initial begin
      reset = 1; start = 0;
      req_pixel_x = 0; req_pixel_y = 0; req_mode = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      lens_regs = '{24'd32768, 24'd32768, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset settings, extremes of the fields
      queue_word(16'd0, 16'd0, 1'b0);
      queue_word(16'hffff, 16'hffff, 1'b0);
      queue_word(16'hffff, 16'd0, 1'b1);
      queue_word(16'h5555, 16'haaaa, 1'b1);
      drain();

      // typical camera with distortion
      csr_write(REG_INV_FX, 32'd4194);
      csr_write(REG_INV_FY, 32'd4194);
      csr_write(REG_OFF_X, -32'sd671088);
      csr_write(REG_OFF_Y, -32'sd503316);
      csr_write(REG_K1, -32'sd300000);
      csr_write(REG_K2, 32'd90000);
      csr_write(REG_P1, 32'd1000);
      csr_write(REG_P2, -32'sd2000);
      queue_word(16'd0, 16'd0, 1'b1);
      queue_word(16'd10240, 16'd7680, 1'b1);
      queue_word(16'd20480, 16'd15360, 1'b1);
      queue_word(16'd20480, 16'd15360, 1'b0);
      queue_word(16'hffff, 16'hffff, 1'b1);
      drain();

      // extreme registers: saturation on every path; upper data bits ignored
      csr_write(REG_INV_FX, 32'hffffffff);
      csr_write(REG_INV_FY, 32'hff000000);
      csr_write(REG_OFF_X, 32'h00800000);
      csr_write(REG_OFF_Y, 32'h007fffff);
      csr_write(REG_K1, 32'h007fffff);
      csr_write(REG_K2, 32'h00800000);
      csr_write(REG_P1, 32'h00800000);
      csr_write(REG_P2, 32'h007fffff);
      queue_word(16'd0, 16'd0, 1'b0);
      queue_word(16'd0, 16'd0, 1'b1);
      queue_word(16'hffff, 16'hffff, 1'b0);
      queue_word(16'hffff, 16'hffff, 1'b1);
      queue_word(16'h8000, 16'h0001, 1'b1);
      drain();

      // random phases with random settings
      for (int ph = 0; ph < 8; ph++) begin
         bit wild;
         wild = (ph % 3 == 2);
         csr_write(REG_INV_FX, wild ? $urandom : $urandom_range(2000, 8000));
         csr_write(REG_INV_FY, wild ? $urandom : $urandom_range(2000, 8000));
         csr_write(REG_OFF_X, wild ? $urandom : 32'(-32'sd600000 + $urandom_range(0, 200000)));
         csr_write(REG_OFF_Y, wild ? $urandom : 32'(-32'sd500000 + $urandom_range(0, 200000)));
         csr_write(REG_K1, wild ? $urandom : mild_coeff());
         csr_write(REG_K2, wild ? $urandom : mild_coeff());
         csr_write(REG_P1, wild ? $urandom : 32'($signed(mild_coeff()) >>> 4));
         csr_write(REG_P2, wild ? $urandom : 32'($signed(mild_coeff()) >>> 4));
         if (ph == 7) allow_gaps = 0;
         for (int i = 0; i < 100; i++)
            queue_word(16'($urandom), 16'($urandom), $urandom_range(0, 3) != 0);
         drain();
      end

      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/plu_pkg.sv
rtl/plu_norm.sv
rtl/plu_iter.sv
rtl/plu_csr.sv
rtl/pixel_lift_iterative_undistort.sv
tb/pixel_lift_iterative_undistort_test.sv
